[hdl/fuzzy_membership_evaluator_defines.svh]
// ----------------------------------------------------------------------------
// fuzzy membership evaluator assertion macros
// immediate-style wrappers around concurrent properties, empty when SYNTH
// ----------------------------------------------------------------------------
`ifndef FUZZY_MEMBERSHIP_EVALUATOR_DEFINES_SVH
`define FUZZY_MEMBERSHIP_EVALUATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FME_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fme assertion failed");
// next-cycle implication
`define FME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fme assertion failed");
`else
`define FME_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/fme_pkg.sv]
// ----------------------------------------------------------------------------
// fme_pkg
// widths, codes and pipeline payload types of the membership evaluator
// ----------------------------------------------------------------------------
package fme_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 15;

  // differences of two samples need one more bit
  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  // positive slope operands fit in SAMPLE_WIDTH unsigned bits
  localparam int MAG_W  = SAMPLE_WIDTH;
  // degree holds 0 .. 1.0 inclusive
  localparam int DEG_W  = FRAC_BITS + 1;

  localparam int DIV_STAGES     = 5;
  localparam int BITS_PER_STAGE = (FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int QUO_W          = DIV_STAGES * BITS_PER_STAGE;
  localparam int QUO_SHIFT      = QUO_W - FRAC_BITS;

  localparam logic [DEG_W-1:0] DEGREE_ONE  = DEG_W'(1) << FRAC_BITS;
  localparam logic [DEG_W-1:0] DEGREE_ZERO = '0;

  localparam int SHAPE_W = 2;
  localparam int INDEX_W = 3;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_RISE  = 2'd0,
    SHAPE_FALL  = 2'd1,
    SHAPE_TRI   = 2'd2,
    SHAPE_TRAP  = 2'd3
  } shape_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_SHAPE   = 3'd0,
    REG_POINT_A = 3'd1,
    REG_POINT_B = 3'd2,
    REG_POINT_C = 3'd3,
    REG_POINT_D = 3'd4
  } reg_index_t;

  typedef struct packed {
    shape_t                          shape;
    logic signed [SAMPLE_WIDTH-1:0]  point_a;
    logic signed [SAMPLE_WIDTH-1:0]  point_b;
    logic signed [SAMPLE_WIDTH-1:0]  point_c;
    logic signed [SAMPLE_WIDTH-1:0]  point_d;
  } fme_cfg_t;

  // payload carried down the divider pipeline
  typedef struct packed {
    logic              slope;   // degree comes from the quotient
    logic [DEG_W-1:0]  fixed;   // degree when no slope is taken
    logic [MAG_W-1:0]  rem;     // partial remainder, below den when slope is set
    logic [MAG_W-1:0]  den;
    logic [QUO_W-1:0]  quo;
  } fme_div_t;

endpackage

[hdl/fme_decode.sv]
// ----------------------------------------------------------------------------
// fme_decode
// first pipeline stage: breakpoint compares, segment select, slope operands
// ----------------------------------------------------------------------------
module fme_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [fme_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  fme_pkg::fme_cfg_t                cfg,
  output logic                             valid_r,
  output fme_pkg::fme_div_t                data_r
);
  import fme_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [DIFF_W-1:0]       x_a, b_x, b_a, c_x, c_b, d_x, d_c;
  logic signed [DIFF_W-1:0]       num, den;
  logic                           take_slope;
  logic [DEG_W-1:0]               fixed;
  fme_div_t                       data_nxt;

  assign x   = in_sample;
  assign x_a = DIFF_W'(x) - DIFF_W'(cfg.point_a);
  assign b_x = DIFF_W'(cfg.point_b) - DIFF_W'(x);
  assign b_a = DIFF_W'(cfg.point_b) - DIFF_W'(cfg.point_a);
  assign c_x = DIFF_W'(cfg.point_c) - DIFF_W'(x);
  assign c_b = DIFF_W'(cfg.point_c) - DIFF_W'(cfg.point_b);
  assign d_x = DIFF_W'(cfg.point_d) - DIFF_W'(x);
  assign d_c = DIFF_W'(cfg.point_d) - DIFF_W'(cfg.point_c);

  always_comb begin
    take_slope = 1'b0;
    fixed      = DEGREE_ZERO;
    num        = x_a;
    den        = b_a;
    unique case (cfg.shape)
      SHAPE_RISE: begin
        if (x <= cfg.point_a) fixed = DEGREE_ZERO;
        else if (x >= cfg.point_b) fixed = DEGREE_ONE;
        else take_slope = 1'b1;
      end
      SHAPE_FALL: begin
        num = b_x;
        if (x <= cfg.point_a) begin
          fixed = DEGREE_ONE;
        end else if (x >= cfg.point_b) begin
          fixed = DEGREE_ZERO;
        end else begin
          take_slope = 1'b1;
        end
      end
      SHAPE_TRI: begin
        if (x <= cfg.point_a) begin
          fixed = DEGREE_ZERO;
        end else if (x == cfg.point_b) begin
          fixed = DEGREE_ONE;
        end else if (x < cfg.point_b) begin
          take_slope = 1'b1;
        end else if (x >= cfg.point_c) begin
          fixed = DEGREE_ZERO;
        end else begin
          take_slope = 1'b1;
          num        = c_x;
          den        = c_b;
        end
      end
      SHAPE_TRAP: begin
        if (x <= cfg.point_a) begin
          fixed = DEGREE_ZERO;
        end else if (x >= cfg.point_b && x <= cfg.point_c) begin
          fixed = DEGREE_ONE;
        end else if (x < cfg.point_b) begin
          take_slope = 1'b1;
        end else if (x >= cfg.point_d) begin
          fixed = DEGREE_ZERO;
        end else begin
          take_slope = 1'b1;
          num        = d_x;
          den        = d_c;
        end
      end
      default: begin
        fixed = DEGREE_ZERO;
      end
    endcase
    // non-positive operands give zero
    if (take_slope && (num <= 0 || den <= 0)) begin
      take_slope = 1'b0;
      fixed      = DEGREE_ZERO;
    end
    data_nxt.slope = take_slope;
    data_nxt.fixed = fixed;
    data_nxt.rem   = num[MAG_W-1:0];
    data_nxt.den   = den[MAG_W-1:0];
    data_nxt.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hdl/fme_div_stage.sv]
// ----------------------------------------------------------------------------
// fme_div_stage
// one restoring division stage, BITS_PER_STAGE quotient bits per clock when adv is high
// ----------------------------------------------------------------------------
module fme_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  fme_pkg::fme_div_t in_data,
  output logic              valid_r,
  output fme_pkg::fme_div_t data_r
);
  import fme_pkg::*;

  fme_div_t         data_nxt;
  logic [MAG_W:0]   rem_sh;

  always_comb begin
    data_nxt = in_data;
    rem_sh   = '0;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      rem_sh = {data_nxt.rem, 1'b0};
      if (rem_sh >= {1'b0, data_nxt.den}) begin
        rem_sh       = rem_sh - {1'b0, data_nxt.den};
        data_nxt.quo = {data_nxt.quo[QUO_W-2:0], 1'b1};
      end else begin
        data_nxt.quo = {data_nxt.quo[QUO_W-2:0], 1'b0};
      end
      data_nxt.rem = rem_sh[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

[hdl/fuzzy_membership_evaluator.sv]
// ----------------------------------------------------------------------------
// fuzzy_membership_evaluator
// trapezoidal-family membership degree of a signed sample, Q1.15 result
// ----------------------------------------------------------------------------
// usage
//   config: cfg_valid/cfg_ready write cfg_data to register cfg_index
//     (0 shape, 1..4 breakpoints a..d); cfg_ready is always high, write only
//     while no transaction is in flight
//   input: one sample per transaction on in_valid/in_stall/in_sample
//   output: one degree per sample on out_valid/out_stall/out_degree,
//     0 .. 32768 where 32768 is 1.0
//   pipeline: the decode register loads at the accepting edge, then five
//     divider stages of three quotient bits each and one output register
//     follow
//   throughput: one sample per cycle unless stalled, set by the pipelined restoring divider
//   stall: each stage moves when it is empty or the one after it moves, so
//     bubbles squeeze out; in_stall rises only when every stage is full and
//     out_stall is high
//   reset: synchronous active low, clears all stage valid bits and sets the
//     configuration registers to zero (rising ramp, all breakpoints 0)
// ----------------------------------------------------------------------------
`include "fuzzy_membership_evaluator_defines.svh"

module fuzzy_membership_evaluator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fme_pkg::INDEX_W-1:0]           cfg_index,
  input  logic [fme_pkg::SAMPLE_WIDTH-1:0]      cfg_data,
  // sample channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fme_pkg::SAMPLE_WIDTH-1:0] in_sample,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fme_pkg::DEG_W-1:0]             out_degree
);
  import fme_pkg::*;

  // configuration registers
  fme_cfg_t cfg_r;

  // stage 0 is decode, stages 1..DIV_STAGES are divider stages
  logic     stage_valid [0:DIV_STAGES];
  fme_div_t stage_data  [0:DIV_STAGES];
  // adv[i] lets stage i load, adv[DIV_STAGES+1] lets the output register load
  logic     adv [0:DIV_STAGES+1];

  logic             out_valid_r;
  logic [DEG_W-1:0] out_degree_r;
  logic [DEG_W-1:0] degree_nxt;
  logic [QUO_W-1:0] quo_scaled;

  // register writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{shape: SHAPE_RISE, default: '0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHAPE:   cfg_r.shape   <= shape_t'(cfg_data[SHAPE_W-1:0]);
        REG_POINT_A: cfg_r.point_a <= cfg_data;
        REG_POINT_B: cfg_r.point_b <= cfg_data;
        REG_POINT_C: cfg_r.point_c <= cfg_data;
        REG_POINT_D: cfg_r.point_d <= cfg_data;
        default: begin
          // indexes past the list are ignored
        end
      endcase
    end
  end

  // backward flow control: a stage loads when it is empty or drains
  always_comb begin
    adv[DIV_STAGES+1] = !out_valid_r || !out_stall;
    for (int i = DIV_STAGES; i >= 0; i--) begin
      adv[i] = !stage_valid[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  fme_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv[0]),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .cfg       (cfg_r),
    .valid_r   (stage_valid[0]),
    .data_r    (stage_data[0])
  );

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    fme_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv[g]),
      .in_valid (stage_valid[g-1]),
      .in_data  (stage_data[g-1]),
      .valid_r  (stage_valid[g]),
      .data_r   (stage_data[g])
    );
  end

  // slope: drop the extra quotient bits, then saturate to 1.0; else the fixed degree
  always_comb begin
    quo_scaled = stage_data[DIV_STAGES].quo >> QUO_SHIFT;
    if (stage_data[DIV_STAGES].slope) begin
      degree_nxt = DEG_W'(quo_scaled);
      if (degree_nxt > DEGREE_ONE) begin
        degree_nxt = DEGREE_ONE;
      end
    end else begin
      degree_nxt = stage_data[DIV_STAGES].fixed;
    end
  end

  // output register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv[DIV_STAGES+1]) begin
      out_valid_r <= stage_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[DIV_STAGES+1]) begin
      out_degree_r <= degree_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_degree = out_degree_r;

  // input side only stalls when the whole pipe is blocked at the output
  `FME_ASSERT_IMPL(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall)
  // degree never exceeds 1.0
  `FME_ASSERT_IMPL(a_degree_range, clk, rst_n, out_valid, out_degree <= DEGREE_ONE)
  // divider remainder stays below the divisor at the last stage
  `FME_ASSERT_IMPL(a_rem_below_den, clk, rst_n,
    stage_valid[DIV_STAGES] && stage_data[DIV_STAGES].slope,
    stage_data[DIV_STAGES].rem < stage_data[DIV_STAGES].den)

endmodule
